// ===== rtl/core/npcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the nearest palette colour mapper.
package npcm_pkg;

   localparam int INDEX_W           = 8;
   localparam int COMP_W            = 12;
   localparam int PIXEL_W           = 8;
   localparam int DIST_OUT_W        = 26;
   localparam int SIZE_W            = 9;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int FRACTION_BITS_DEF = 4;

   localparam logic CSR_REG_SIZE = 1'b0;

   typedef enum logic [0:0] {
      ACT_LOAD  = 1'b0,
      ACT_PIXEL = 1'b1
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [INDEX_W-1:0]  entry_index;
      logic [COMP_W-1:0]   entry_red;
      logic [COMP_W-1:0]   entry_green;
      logic [COMP_W-1:0]   entry_blue;
      logic [PIXEL_W-1:0]  pixel_red;
      logic [PIXEL_W-1:0]  pixel_green;
      logic [PIXEL_W-1:0]  pixel_blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]    best_index;
      logic [COMP_W-1:0]     best_red;
      logic [COMP_W-1:0]     best_green;
      logic [COMP_W-1:0]     best_blue;
      logic [DIST_OUT_W-1:0] best_distance_sq;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      req_type            req;
      logic [INDEX_W-1:0] best_index;
      logic [COMP_W-1:0]  best_red;
      logic [COMP_W-1:0]  best_green;
      logic [COMP_W-1:0]  best_blue;
   } chain_type;

   function automatic int dist_width(input int frac_bits);
      int pix_w;
      int cmp_w;
      pix_w = PIXEL_W + frac_bits;
      cmp_w = (pix_w > COMP_W) ? pix_w : COMP_W;
      return 2 * cmp_w + 2;
   endfunction

endpackage

// ===== rtl/core/npcm_cell.sv =====
`timescale 1ns / 1ps
// One palette cell: holds an entry, squares the differences, keeps the running minimum.
module npcm_cell #(
   parameter int CELL_INDEX    = 0,
   parameter int FRACTION_BITS = npcm_pkg::FRACTION_BITS_DEF,
   parameter int DIST_W        = npcm_pkg::dist_width(npcm_pkg::FRACTION_BITS_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  npcm_pkg::chain_type up_item,
   input  logic [DIST_W-1:0]   up_dist,
   output npcm_pkg::chain_type dn_item,
   output logic [DIST_W-1:0]   dn_dist
);
   import npcm_pkg::*;

   localparam int PIX_W = PIXEL_W + FRACTION_BITS;
   localparam int CMP_W = (PIX_W > COMP_W) ? PIX_W : COMP_W;
   localparam int SQ_W  = 2 * CMP_W;
   localparam logic [INDEX_W-1:0] CELL_ID = INDEX_W'(CELL_INDEX);

   logic [2:0][COMP_W-1:0] entry_ff;
   logic [2:0][COMP_W-1:0] s1_col_ff;
   logic [2:0][SQ_W-1:0]   sq_ff;
   logic [2:0][SQ_W-1:0]   sq_in;
   logic [2:0][CMP_W-1:0]  pix_x;
   logic [2:0][CMP_W-1:0]  ent_x;
   logic [2:0][CMP_W-1:0]  dif;
   logic [2:0][PIXEL_W-1:0] pix_raw;
   logic [2:0][COMP_W-1:0] load_col;
   chain_type              s1_item_ff;
   logic [DIST_W-1:0]      s1_dist_ff;
   chain_type              dn_item_ff;
   chain_type              dn_item_in;
   logic [DIST_W-1:0]      dn_dist_ff;
   logic [DIST_W-1:0]      dn_dist_in;
   logic [DIST_W-1:0]      sum_in;
   logic                   entry_hit;
   logic                   take;

   assign pix_raw  = {up_item.req.pixel_blue, up_item.req.pixel_green, up_item.req.pixel_red};
   assign load_col = {up_item.req.entry_blue, up_item.req.entry_green, up_item.req.entry_red};
   assign entry_hit = up_item.valid && (up_item.req.action == ACT_LOAD)
                      && (up_item.req.entry_index == CELL_ID);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pix_x[c] = CMP_W'(PIX_W'(pix_raw[c]) << FRACTION_BITS);
         ent_x[c] = CMP_W'(entry_ff[c]);
         dif[c]   = (ent_x[c] >= pix_x[c]) ? (ent_x[c] - pix_x[c]) : (pix_x[c] - ent_x[c]);
         sq_in[c] = SQ_W'(dif[c]) * SQ_W'(dif[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (entry_hit) begin
         entry_ff <= load_col;
      end
      s1_dist_ff <= up_dist;
      s1_col_ff  <= entry_ff;
      sq_ff      <= sq_in;
      if (reset) begin
         s1_item_ff <= '0;
      end else begin
         s1_item_ff <= up_item;
      end
   end

   assign sum_in = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
   assign take   = enable && s1_item_ff.valid && (s1_item_ff.req.action == ACT_PIXEL)
                   && (sum_in < s1_dist_ff);

   always_comb begin
      dn_item_in = s1_item_ff;
      dn_dist_in = s1_dist_ff;
      if (take) begin
         dn_item_in.best_index = CELL_ID;
         dn_item_in.best_red   = s1_col_ff[0];
         dn_item_in.best_green = s1_col_ff[1];
         dn_item_in.best_blue  = s1_col_ff[2];
         dn_dist_in            = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      dn_dist_ff <= dn_dist_in;
      if (reset) begin
         dn_item_ff <= '0;
      end else begin
         dn_item_ff <= dn_item_in;
      end
   end

   assign dn_item = dn_item_ff;
   assign dn_dist = dn_dist_ff;

endmodule

// ===== rtl/core/nearest_palette_color_mapper.sv =====
`timescale 1ns / 1ps
// A pixel request passes both stages of each cell, then the output register, to its rsp_strobe beat.
// Throughput: one item per cycle; each palette cell holds two register stages.
// busy stays low, so start is taken in every cycle; the receiver cannot stall.
// Reset clears the cell pipeline and sets palette_size to 1.
// Palette entries are undefined after reset until loaded.
module nearest_palette_color_mapper #(
   parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF,
   parameter int FRACTION_BITS = npcm_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  npcm_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output npcm_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [npcm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [npcm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [npcm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import npcm_pkg::*;

   localparam int DIST_W = dist_width(FRACTION_BITS);

   logic [SIZE_W-1:0]       size_ff;
   logic [SIZE_W-1:0]       size_in;
   logic                    csr_write;
   chain_type               head_item;
   chain_type               item_chain [0:PALETTE_DEPTH];
   logic [DIST_W-1:0]       dist_chain [0:PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] cell_en;
   logic                    rsp_strobe_ff;
   logic                    rsp_strobe_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_REG_SIZE);
   assign size_in   = csr_write ? pwdata[SIZE_W-1:0] : size_ff;
   assign prdata    = (paddr[2] == CSR_REG_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      head_item       = '0;
      head_item.valid = start && !busy;
      head_item.req   = req_data;
   end

   assign item_chain[0] = head_item;
   assign dist_chain[0] = '1;

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      assign cell_en[k] = (k == 0) || (SIZE_W'(k) < size_ff);
      npcm_cell #(
         .CELL_INDEX   (k),
         .FRACTION_BITS(FRACTION_BITS),
         .DIST_W       (DIST_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (cell_en[k]),
         .up_item(item_chain[k]),
         .up_dist(dist_chain[k]),
         .dn_item(item_chain[k+1]),
         .dn_dist(dist_chain[k+1])
      );
   end

   always_comb begin
      rsp_strobe_in = item_chain[PALETTE_DEPTH].valid
                      && (item_chain[PALETTE_DEPTH].req.action == ACT_PIXEL);
      rsp_in.best_index       = item_chain[PALETTE_DEPTH].best_index;
      rsp_in.best_red         = item_chain[PALETTE_DEPTH].best_red;
      rsp_in.best_green       = item_chain[PALETTE_DEPTH].best_green;
      rsp_in.best_blue        = item_chain[PALETTE_DEPTH].best_blue;
      rsp_in.best_distance_sq = DIST_OUT_W'(dist_chain[PALETTE_DEPTH]);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/core/npcm_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the nearest palette colour mapper, bound to the top level.
module npcm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_strobe,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [npcm_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [npcm_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [npcm_pkg::CSR_DATA_W-1:0] prdata,
   input logic                            pready
);
   import npcm_pkg::*;

   a_no_beat_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result beat straight after reset");

   a_pready_high: assert property (@(posedge clock)
      pready)
      else $error("pready dropped");

   a_size_readback: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(psel && penable && pwrite && (paddr[2] == CSR_REG_SIZE))
       && (paddr[2] == CSR_REG_SIZE))
      |-> (prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0])))
      else $error("palette_size readback differs from the written value");

   a_prdata_upper_zero: assert property (@(posedge clock)
      prdata[CSR_DATA_W-1:SIZE_W] == '0)
      else $error("unused prdata bits set");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);
